// ===== hw/rtl/bleadp_pkg.sv =====
// Package for the BLE advertising data parser: item types, element codes,
// parse phases and the AD type classification table. No dependencies.
package bleadp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] TYPE_MFR    = 8'hFF;
    localparam logic [4:0] PREFIX_DONE = 5'd31;
    localparam logic [4:0] UUID_BYTES_128 = 5'd16;

    // Result element codes
    typedef enum logic [3:0] {
        KIND_FLAGS    = 4'd0,
        KIND_SVC_UUID = 4'd1,
        KIND_SOL_UUID = 4'd2,
        KIND_NAME     = 4'd3,
        KIND_TX_POWER = 4'd4,
        KIND_SD_UUID  = 4'd5,
        KIND_SD_BYTE  = 4'd6,
        KIND_MFR_BYTE = 4'd7,
        KIND_MFR_SHORT = 4'd8,
        KIND_DONE     = 4'd9,
        KIND_TRUNC    = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CAT_NONE  = 3'd0,
        CAT_FLAGS = 3'd1,
        CAT_SVC   = 3'd2,
        CAT_SOL   = 3'd3,
        CAT_NAME  = 3'd4,
        CAT_TX    = 3'd5,
        CAT_SD    = 3'd6,
        CAT_MFR   = 3'd7
    } cat_t;

    // End-of-record result that may follow the element of the same byte
    typedef enum logic [1:0] {
        TR_NONE  = 2'd0,
        TR_DONE  = 2'd1,
        TR_TRUNC = 2'd2
    } trail_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  element_kind;
        logic [4:0]  uuid_size;
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic        last_of_run;
    } out_item_t;

    // One classified byte: an optional element and an optional trailer
    typedef struct packed {
        logic        prim_valid;
        kind_t       prim_kind;
        logic [4:0]  prim_size;
        logic [63:0] prim_low;
        logic [63:0] prim_high;
        trail_t      trail;
    } entry_t;

    typedef struct packed {
        cat_t       cat;
        logic [4:0] size;
    } class_t;

    function automatic class_t classify(input logic [7:0] t);
        class_t c;
        c.cat  = CAT_NONE;
        c.size = 5'd0;
        unique case (t)
            8'h01:        c.cat = CAT_FLAGS;
            8'h02, 8'h03: begin c.cat = CAT_SVC; c.size = 5'd2; end
            8'h04, 8'h05: begin c.cat = CAT_SVC; c.size = 5'd4; end
            8'h06, 8'h07: begin c.cat = CAT_SVC; c.size = 5'd16; end
            8'h14:        begin c.cat = CAT_SOL; c.size = 5'd2; end
            8'h1F:        begin c.cat = CAT_SOL; c.size = 5'd4; end
            8'h15:        begin c.cat = CAT_SOL; c.size = 5'd16; end
            8'h08, 8'h09: c.cat = CAT_NAME;
            8'h0A:        c.cat = CAT_TX;
            8'h16:        begin c.cat = CAT_SD; c.size = 5'd2; end
            8'h20:        begin c.cat = CAT_SD; c.size = 5'd4; end
            8'h21:        begin c.cat = CAT_SD; c.size = 5'd16; end
            TYPE_MFR:     c.cat = CAT_MFR;
            default:      c.cat = CAT_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/bleadp_front.sv =====
// Front end: accepts record bytes, walks the length/type structures and
// pushes one classified entry per byte that yields results. Uses bleadp_pkg.
module bleadp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bleadp_pkg::in_item_t in_item,
    input  logic                 q_full,
    output logic                 q_push,
    output bleadp_pkg::entry_t   q_entry
);
    import bleadp_pkg::*;

    phase_t       phase_reg,   phase_next;
    logic [7:0]   left_reg,    left_next;
    logic [7:0]   type_reg,    type_next;
    logic [4:0]   count_reg,   count_next;
    logic [127:0] uuid_reg,    uuid_next;
    logic [15:0]  company_reg, company_next;

    logic [7:0]   b;
    logic         accept;
    class_t       cls;
    logic         size16;
    logic [127:0] base;
    logic [127:0] g_uuid;
    logic [5:0]   idx_inc;
    logic         g_done;
    logic [4:0]   g_count;
    logic [5:0]   sh;
    logic [7:0]   left_dec;
    entry_t       ent;

    assign b        = in_item.data_byte;
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // UUID gather: 128-bit ones shift in first byte most significant,
    // short ones are placed little endian
    always_comb
    begin
        cls     = classify(type_reg);
        size16  = (cls.size == UUID_BYTES_128);
        base    = (count_reg == 5'd0) ? 128'd0 : uuid_reg;
        sh      = {count_reg[2:0], 3'b000};
        idx_inc = {1'b0, count_reg} + 6'd1;
        g_done  = (idx_inc >= {1'b0, cls.size});
        g_count = g_done ? 5'd0 : idx_inc[4:0];
        if (size16)
        begin
            g_uuid = {base[119:0], b};
        end
        else
        begin
            g_uuid = {base[127:64], base[63:0] | (64'(b) << sh)};
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        type_next    = type_reg;
        count_next   = count_reg;
        uuid_next    = uuid_reg;
        company_next = company_reg;
        left_dec     = left_reg - 8'd1;

        ent.prim_valid = 1'b0;
        ent.prim_kind  = KIND_FLAGS;
        ent.prim_size  = 5'd0;
        ent.prim_low   = 64'd0;
        ent.prim_high  = 64'd0;
        ent.trail      = TR_NONE;

        unique case (phase_reg)
            PH_LEN:
            begin
                if (b == 8'd0)
                begin
                    ent.prim_valid = 1'b1;
                    ent.prim_kind  = KIND_DONE;
                    phase_next     = PH_DONE;
                end
                else
                begin
                    left_next  = b - 8'd1;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next    = b;
                count_next   = 5'd0;
                uuid_next    = 128'd0;
                company_next = 16'd0;
                if (left_reg == 8'd0)
                begin
                    if (b == TYPE_MFR)
                    begin
                        ent.prim_valid = 1'b1;
                        ent.prim_kind  = KIND_MFR_SHORT;
                    end
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                unique case (cls.cat)
                    CAT_FLAGS, CAT_TX:
                    begin
                        if (count_reg == 5'd0)
                        begin
                            ent.prim_valid = 1'b1;
                            ent.prim_kind  = (cls.cat == CAT_FLAGS) ? KIND_FLAGS
                                                                    : KIND_TX_POWER;
                            ent.prim_low   = 64'(b);
                            count_next     = PREFIX_DONE;
                        end
                    end
                    CAT_SVC, CAT_SOL:
                    begin
                        count_next = g_count;
                        uuid_next  = g_uuid;
                        if (g_done)
                        begin
                            ent.prim_valid = 1'b1;
                            ent.prim_kind  = (cls.cat == CAT_SVC) ? KIND_SVC_UUID
                                                                  : KIND_SOL_UUID;
                            ent.prim_size  = cls.size;
                            ent.prim_low   = g_uuid[63:0];
                            ent.prim_high  = size16 ? g_uuid[127:64] : 64'd0;
                        end
                    end
                    CAT_NAME:
                    begin
                        ent.prim_valid = 1'b1;
                        ent.prim_kind  = KIND_NAME;
                        ent.prim_low   = 64'(b);
                    end
                    CAT_SD:
                    begin
                        if (count_reg == PREFIX_DONE)
                        begin
                            ent.prim_valid = 1'b1;
                            ent.prim_kind  = KIND_SD_BYTE;
                            ent.prim_low   = 64'(b);
                        end
                        else
                        begin
                            count_next = g_count;
                            uuid_next  = g_uuid;
                            if (g_done)
                            begin
                                ent.prim_valid = 1'b1;
                                ent.prim_kind  = KIND_SD_UUID;
                                ent.prim_size  = cls.size;
                                ent.prim_low   = g_uuid[63:0];
                                ent.prim_high  = size16 ? g_uuid[127:64] : 64'd0;
                                count_next     = PREFIX_DONE;
                            end
                        end
                    end
                    CAT_MFR:
                    begin
                        if (count_reg == 5'd0)
                        begin
                            company_next = {8'd0, b};
                            count_next   = 5'd1;
                        end
                        else if (count_reg == 5'd1)
                        begin
                            company_next = {b, company_reg[7:0]};
                            count_next   = PREFIX_DONE;
                        end
                        else
                        begin
                            ent.prim_valid = 1'b1;
                            ent.prim_kind  = KIND_MFR_BYTE;
                            ent.prim_low   = 64'(b);
                            ent.prim_high  = 64'(company_reg);
                        end
                    end
                    CAT_NONE:
                    begin
                    end
                endcase

                left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    // company id never completed
                    if (type_reg == TYPE_MFR && count_next != PREFIX_DONE)
                    begin
                        ent.prim_valid = 1'b1;
                        ent.prim_kind  = KIND_MFR_SHORT;
                    end
                    phase_next = PH_LEN;
                end
            end
            PH_DONE:
            begin
            end
        endcase

        if (in_item.record_end)
        begin
            if (phase_next == PH_TYPE || phase_next == PH_DATA)
            begin
                ent.trail = TR_TRUNC;
            end
            else if (phase_next == PH_LEN)
            begin
                ent.trail = TR_DONE;
            end
            phase_next   = PH_LEN;
            left_next    = 8'd0;
            type_next    = 8'd0;
            count_next   = 5'd0;
            uuid_next    = 128'd0;
            company_next = 16'd0;
        end
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.prim_valid || ent.trail != TR_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEN;
            left_reg    <= 8'd0;
            type_reg    <= 8'd0;
            count_reg   <= 5'd0;
            uuid_reg    <= 128'd0;
            company_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            type_reg    <= type_next;
            count_reg   <= count_next;
            uuid_reg    <= uuid_next;
            company_reg <= company_next;
        end
    end

`ifndef SYNTHESIS
    a_prefix_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 5'd15 || count_reg == PREFIX_DONE)
        else $error("front: gather count out of range");
`endif

endmodule

// ===== hw/rtl/bleadp_queue.sv =====
// Short queue of classified entries between front and back end.
// Flip-flop storage, one push and one pop per cycle. Uses bleadp_pkg.
module bleadp_queue #(
    parameter int DEPTH = bleadp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bleadp_pkg::entry_t push_entry,
    input  logic               pop,
    output bleadp_pkg::entry_t head,
    output logic               full,
    output logic               empty
);
    import bleadp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue: push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue: pop while empty");
`endif

endmodule

// ===== hw/rtl/bleadp_back.sv =====
// Back end: unpacks queue entries into result items, one per cycle while
// out_ready allows, and holds them in the output register. Uses bleadp_pkg.
module bleadp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bleadp_pkg::entry_t    q_head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bleadp_pkg::out_item_t out_item
);
    import bleadp_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg,  out_item_next;
    logic      half_reg,      half_next;

    logic load;
    logic has_trail;
    logic send_prim;

    always_comb
    begin
        load      = !out_valid_reg || out_ready;
        has_trail = (q_head.trail != TR_NONE);
        send_prim = q_head.prim_valid && !half_reg;

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        half_next      = half_reg;
        q_pop          = 1'b0;

        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                if (send_prim)
                begin
                    out_item_next.element_kind = q_head.prim_kind;
                    out_item_next.uuid_size    = q_head.prim_size;
                    out_item_next.value_low    = q_head.prim_low;
                    out_item_next.value_high   = q_head.prim_high;
                    out_item_next.last_of_run  = !has_trail;
                    half_next = has_trail;
                    q_pop     = !has_trail;
                end
                else
                begin
                    out_item_next.element_kind = (q_head.trail == TR_DONE) ? KIND_DONE
                                                                           : KIND_TRUNC;
                    out_item_next.uuid_size    = 5'd0;
                    out_item_next.value_low    = 64'd0;
                    out_item_next.value_high   = 64'd0;
                    out_item_next.last_of_run  = 1'b1;
                    half_next = 1'b0;
                    q_pop     = 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

`ifndef SYNTHESIS
    a_half_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (!q_empty && q_head.prim_valid && q_head.trail != TR_NONE))
        else $error("back: split entry lost its queue head");
    a_half_then_trail: assert property (@(posedge clk) disable iff (!rst_n)
        (half_reg && load) |=> (out_valid_reg && out_item_reg.last_of_run))
        else $error("back: trailer did not follow split element");
`endif

endmodule

// ===== hw/rtl/ble_advertising_data_parser_top.sv =====
// BLE advertising data parser, top level.
// Instantiates bleadp_front, bleadp_queue and bleadp_back; uses bleadp_pkg.
//
// Takes one advertising record byte per item (record_end marks the last byte)
// and walks the length/type structures, producing parsed elements: flags,
// tx power, service and solicitation UUIDs, local name bytes, service data
// UUID and bytes, manufacturer bytes tagged with the company id, and done or
// truncated at the end of a record. A byte yields zero, one or two results;
// last_of_run marks the final result of each byte. The front end accepts a
// byte every cycle as long as the entry queue (QUEUE_DEPTH entries) has room,
// independent of the output side. The back end delivers one result per cycle,
// as long as out_ready takes them, from an output register, so a byte that
// yields an element plus an end-of-record result gives two results in turn.
// A byte's first result reaches out_valid through the queue write and then
// the output register. There is no configuration and no clearing pass after
// reset.
module ble_advertising_data_parser_top #(
    parameter int QUEUE_DEPTH = bleadp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bleadp_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bleadp_pkg::out_item_t out_item
);
    import bleadp_pkg::*;

    // front to queue
    logic   q_push;
    entry_t q_push_entry;
    logic   q_full;

    // queue to back
    logic   q_pop;
    entry_t q_head;
    logic   q_empty;

    bleadp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    bleadp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    bleadp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
